FILE: rtl/core/rtfp_pkg.sv
// Shared types and constants for the RGB565 triangle fade pixel block.
package rtfp_pkg;

	localparam int COORD_BITS = 6;

	// Division cell counts: period, phase remainder, phase fraction
	localparam int DIV1_CELLS = 24;
	localparam int DIV2_CELLS = 32;
	localparam int DIV3_CELLS = 16;
	localparam int NUM_CELLS  = DIV1_CELLS + DIV2_CELLS + DIV3_CELLS;

	localparam logic [15:0] BASE_PERIOD_RST = 16'd1000;

	typedef struct packed {
		logic [31:0]           time_ms;
		logic [31:0]           offset_ms;
		logic [15:0]           speed_q8;
		logic [15:0]           start_color;
		logic [15:0]           end_color;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic [15:0]           out_color;
	} pix_out_t;

	// Everything one item carries down the row of division cells
	typedef struct packed {
		logic [23:0]           rem;
		logic [23:0]           dvsr;
		logic [31:0]           dvnd;
		logic [23:0]           quot;
		logic [31:0]           aux;
		logic                  hold;
		logic [15:0]           start_color;
		logic [15:0]           end_color;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} lane_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic en;
		logic valid;
	} cell_ctl_t;

endpackage

FILE: rtl/core/rtfp_div_cell.sv
// One restoring-division cell: one quotient bit per item, registered.
module rtfp_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rtfp_pkg::cell_ctl_t ctl,
	input  rtfp_pkg::lane_t    lane_in,
	output logic               valid_s1,
	output rtfp_pkg::lane_t    lane_s1
);
	import rtfp_pkg::*;

	logic [24:0] trial;
	logic [25:0] diff;
	logic        fits;
	lane_t       lane_nxt;

	always_comb begin
		trial    = {lane_in.rem, lane_in.dvnd[31]};
		diff     = {1'b0, trial} - {2'b00, lane_in.dvsr};
		fits     = !diff[25];
		lane_nxt = lane_in;
		lane_nxt.rem  = fits ? diff[23:0] : trial[23:0];
		lane_nxt.dvnd = {lane_in.dvnd[30:0], 1'b0};
		lane_nxt.quot = {lane_in.quot[22:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
		end
	end

	// Payload: advance with the row, no reset
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			lane_s1 <= lane_nxt;
		end
	end

endmodule

FILE: rtl/core/rtfp_blend.sv
// Triangle fold of the phase fraction and per-channel RGB565 blend.
module rtfp_blend (
	input  logic [15:0] frac,
	input  logic        hold,
	input  logic [15:0] start_color,
	input  logic [15:0] end_color,
	output logic [15:0] color
);
	import rtfp_pkg::*;

	logic [16:0] prog;
	logic [16:0] down;
	logic [5:0]  r_mix;
	logic [5:0]  g_mix;
	logic [5:0]  b_mix;

	function automatic logic [5:0] mix6(input logic [5:0] a, input logic [5:0] b,
		input logic [16:0] p);
		logic [16:0] q;
		logic [23:0] acc;
		q   = 17'h10000 - p;
		acc = 24'(a * q) + 24'(b * p);
		return acc[21:16];
	endfunction

	always_comb begin
		down = 17'h10000 - {1'b0, frac};
		if (hold) begin
			prog = '0;
		end else if (!frac[15]) begin
			prog = {frac, 1'b0};
		end else begin
			prog = {down[15:0], 1'b0};
		end
		r_mix = mix6({1'b0, start_color[15:11]}, {1'b0, end_color[15:11]}, prog);
		g_mix = mix6(start_color[10:5], end_color[10:5], prog);
		b_mix = mix6({1'b0, start_color[4:0]}, {1'b0, end_color[4:0]}, prog);
		color = {r_mix[4:0], g_mix, b_mix[4:0]};
	end

endmodule

FILE: rtl/core/rgb565_triangle_fade_pixel.sv
// Top level of the RGB565 triangle fade pixel block.
//
// Usage: each item on the input channel (item_valid / item_stall / item)
// describes one sprite pixel: tick time, phase offset, 8.8 speed, start and
// end RGB565 colours and position. One result per item leaves on the output
// channel (result_valid / result_stall / result) with the position and the
// faded colour. cfg_wr_en / cfg_wr_data write the fade period at unit speed;
// write it only while no item is in flight.
// Throughput: one item per cycle while item_stall is low. Path: the accepting edge
// loads the input register, then a row of 72 one-bit division cells (24 for the
// period, 32 for the phase remainder, 16 for the Q0.16 phase fraction) and the
// output register, with the colour blend in front of it, which drives result_valid.
// Reset: all stages empty, period register at 1000 ms.
// Stall: when the receiver stalls, a finished item waits in the output
// register while the row keeps moving; the next one lands in a skid
// register. Only with the skid register full does the row hold and
// item_stall rise; item_stall is a plain register output.
module rgb565_triangle_fade_pixel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  rtfp_pkg::pix_in_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output rtfp_pkg::pix_out_t result
);
	import rtfp_pkg::*;

	logic [15:0] base_period_q;
	logic        skid_full_q;
	pix_out_t    skid_q;
	logic        adv;

	logic        valid_s0;
	lane_t       lane_s0;

	lane_t       cell_in  [NUM_CELLS];
	lane_t       cell_out [NUM_CELLS];
	logic        cell_v   [NUM_CELLS];

	lane_t       last;
	logic        last_v;
	logic [15:0] blend_color;
	pix_out_t    fresh;

	// The whole row advances unless the skid register is occupied
	assign adv        = !skid_full_q;
	assign item_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_period_q <= BASE_PERIOD_RST;
		end else if (cfg_wr_en) begin
			base_period_q <= cfg_wr_data;
		end
	end

	// Input register: set up the period division, form the tick sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s0.rem         <= '0;
			lane_s0.dvsr        <= {8'h00, item.speed_q8};
			lane_s0.dvnd        <= {base_period_q, 16'h0000};
			lane_s0.quot        <= '0;
			lane_s0.aux         <= item.time_ms + item.offset_ms;
			lane_s0.hold        <= (item.speed_q8 == 16'h0000);
			lane_s0.start_color <= item.start_color;
			lane_s0.end_color   <= item.end_color;
			lane_s0.pos_x       <= item.pos_x;
			lane_s0.pos_y       <= item.pos_y;
		end
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		cell_ctl_t ctl;

		if (i == 0) begin : g_first
			always_comb begin
				cell_in[i] = lane_s0;
				ctl.en     = adv;
				ctl.valid  = valid_s0;
			end
		end else if (i == DIV1_CELLS) begin : g_to_phase
			// Quotient becomes the period; divide the tick sum by it
			always_comb begin
				cell_in[i]      = cell_out[i-1];
				cell_in[i].hold = cell_out[i-1].hold || (cell_out[i-1].quot == 24'h0);
				cell_in[i].dvsr = cell_out[i-1].quot;
				cell_in[i].dvnd = cell_out[i-1].aux;
				cell_in[i].rem  = '0;
				cell_in[i].quot = '0;
				ctl.en          = adv;
				ctl.valid       = cell_v[i-1];
			end
		end else if (i == DIV1_CELLS + DIV2_CELLS) begin : g_to_frac
			// Keep the remainder as phase; shift in zeros for the fraction
			always_comb begin
				cell_in[i]      = cell_out[i-1];
				cell_in[i].dvnd = '0;
				cell_in[i].quot = '0;
				ctl.en          = adv;
				ctl.valid       = cell_v[i-1];
			end
		end else begin : g_mid
			always_comb begin
				cell_in[i] = cell_out[i-1];
				ctl.en     = adv;
				ctl.valid  = cell_v[i-1];
			end
		end

		rtfp_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.lane_in  (cell_in[i]),
			.valid_s1 (cell_v[i]),
			.lane_s1  (cell_out[i])
		);
	end

	assign last   = cell_out[NUM_CELLS-1];
	assign last_v = cell_v[NUM_CELLS-1];

	rtfp_blend u_blend (
		.frac        (last.quot[15:0]),
		.hold        (last.hold),
		.start_color (last.start_color),
		.end_color   (last.end_color),
		.color       (blend_color)
	);

	always_comb begin
		fresh.out_x     = last.pos_x;
		fresh.out_y     = last.pos_y;
		fresh.out_color = blend_color;
	end

	// Output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_full_q  <= 1'b0;
		end else if (skid_full_q) begin
			// Row holds; drain the skid item once the result is taken
			if (!result_stall) begin
				skid_full_q <= 1'b0;
			end
		end else if (last_v) begin
			if (!result_valid || !result_stall) begin
				result_valid <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!result_stall) begin
				result <= skid_q;
			end
		end else if (last_v) begin
			if (!result_valid || !result_stall) begin
				result <= fresh;
			end else begin
				skid_q <= fresh;
			end
		end
	end

endmodule

FILE: tb/rtfp_checker.sv
// Checker for the RGB565 triangle fade pixel block: watches both channels, predicts and compares.
module rtfp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               item_valid,
	input  logic               item_stall,
	input  rtfp_pkg::pix_in_t  item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  rtfp_pkg::pix_out_t result,
	output int                 fail_count,
	output int                 outstanding,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtfp_pkg::*;

	logic [15:0] fade_base_ms;
	pix_out_t    pending_pixels[$];

	// Floor blend of one channel at Q1.16 progress
	function automatic logic [5:0] blend_chan(logic [5:0] a, logic [5:0] b, logic [16:0] prog);
		logic [23:0] acc;
		acc = a * (17'h10000 - prog) + b * prog;
		return acc[21:16];
	endfunction

	function automatic pix_out_t fade_pixel(logic [15:0] base_ms, pix_in_t px);
		logic [23:0] period;
		logic [31:0] sum;
		logic [23:0] phase;
		logic [39:0] frac_full;
		logic [15:0] frac;
		logic [17:0] fall;
		logic [16:0] prog;
		logic [5:0]  r, g, b;
		pix_out_t    o;
		prog = '0;
		if (px.speed_q8 != 16'd0) begin
			period = {base_ms, 8'h00} / {8'h00, px.speed_q8};
			if (period != 24'd0) begin
				sum       = px.time_ms + px.offset_ms;
				phase     = 24'(sum % period);
				frac_full = {phase, 16'h0000} / period;
				frac      = frac_full[15:0];
				// fold: rise over the first half of the period, fall over the second
				if (!frac[15]) begin
					prog = {frac, 1'b0};
				end else begin
					fall = 18'd131072 - {1'b0, frac, 1'b0};
					prog = fall[16:0];
				end
			end
		end
		r = blend_chan({1'b0, px.start_color[15:11]}, {1'b0, px.end_color[15:11]}, prog);
		g = blend_chan(px.start_color[10:5], px.end_color[10:5], prog);
		b = blend_chan({1'b0, px.start_color[4:0]}, {1'b0, px.end_color[4:0]}, prog);
		o.out_x     = px.pos_x;
		o.out_y     = px.pos_y;
		o.out_color = {r[4:0], g, b[4:0]};
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			fade_base_ms = BASE_PERIOD_RST;
			pending_pixels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				fade_base_ms = cfg_wr_data;
			if (item_valid && !item_stall)
				pending_pixels = {pending_pixels, fade_pixel(fade_base_ms, item)};
			if (result_valid && !result_stall) begin
				checked++;
				if (pending_pixels.size() == 0) begin
					report_mismatch("unexpected result", int'(result), 0);
				end else begin
					want = pending_pixels.pop_front();
					if (result.out_x != want.out_x)
						report_mismatch("out_x", int'(result.out_x), int'(want.out_x));
					if (result.out_y != want.out_y)
						report_mismatch("out_y", int'(result.out_y), int'(want.out_y));
					if (result.out_color != want.out_color)
						report_mismatch("out_color", int'(result.out_color),
							int'(want.out_color));
				end
			end
			outstanding <= pending_pixels.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top for the RGB565 triangle fade pixel block: stimulus, idling and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtfp_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int LONG_HOLD  = 320;
	localparam int DRAIN_WAIT = 100;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [15:0] cfg_wr_data  = '0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	pix_in_t     item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	pix_out_t    result;

	int chk_fails;
	int chk_outstanding;
	int chk_checked;
	int cycles     = 0;
	int sent       = 0;
	int settings   = 0;
	bit hold_req   = 1'b0;
	bit hold_taken = 1'b0;

	pix_in_t directed[$];

	always #5ns clk = ~clk;

	rgb565_triangle_fade_pixel dut (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	rtfp_checker chk (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result,
		.fail_count  (chk_fails),
		.outstanding (chk_outstanding),
		.checked     (chk_checked)
	);

	// Abandon the run if it hangs; the limit sits far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, chk_outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: switch between stall patterns every so often, and serve one long
	// hold-off when asked so that the pipeline and its skid register fill up.
	initial begin : receiver
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 160);
				end
				left--;
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 99) < 25);
					2: result_stall <= ($urandom_range(0, 99) < 70);
					default: result_stall <= ((left % 4) == 0);
				endcase
			end
		end
	end

	function automatic pix_in_t mk_pixel(logic [31:0] t, logic [31:0] off, logic [15:0] spd,
		logic [15:0] sc, logic [15:0] ec, logic [5:0] x, logic [5:0] y);
		pix_in_t px;
		px.time_ms     = t;
		px.offset_ms   = off;
		px.speed_q8    = spd;
		px.start_color = sc;
		px.end_color   = ec;
		px.pos_x       = x;
		px.pos_y       = y;
		return px;
	endfunction

	// Queue one directed pixel at the tail of the list
	task automatic add_directed(input pix_in_t px);
		directed = {directed, px};
	endtask

	function automatic logic [15:0] rand_colour();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Random pixel: speed sometimes zero, else biased towards slow, near-unit, fast and fully random
	function automatic pix_in_t rand_pixel();
		pix_in_t px;
		px.time_ms = $urandom;
		case ($urandom_range(0, 9))
			0: px.offset_ms = 32'h0;
			1: px.offset_ms = 32'hFFFF_FFFF;
			default: px.offset_ms = $urandom;
		endcase
		case ($urandom_range(0, 19))
			0: px.speed_q8 = 16'h0000;
			1, 2, 3, 4: px.speed_q8 = 16'($urandom_range(1, 16));
			5, 6, 7, 8, 9: px.speed_q8 = 16'($urandom_range(200, 320));
			10, 11, 12, 13, 14: px.speed_q8 = 16'($urandom_range(0, 65535));
			default: px.speed_q8 = 16'($urandom_range(16'hF000, 16'hFFFF));
		endcase
		px.start_color = rand_colour();
		px.end_color   = rand_colour();
		px.pos_x       = 6'($urandom_range(0, 63));
		px.pos_y       = 6'($urandom_range(0, 63));
		return px;
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic offer(input pix_in_t px);
		item       <= px;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	// Wait until every predicted result has come back
	task automatic drain();
		do @(posedge clk); while (chk_outstanding != 0);
	endtask

	task automatic set_period(input logic [15:0] ms);
		drain();
		cfg_wr_data <= ms;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		settings++;
	endtask

	// Send n random items in bursts; steady mode sends back to back without gaps
	task automatic send_batch(input int n, input bit steady);
		int burst_left;
		bit gap;
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < n; i++) begin
			offer(rand_pixel());
			burst_left--;
			gap = !steady && burst_left == 0;
			if (gap || i == n - 1)
				item_valid <= 1'b0;
			if (gap) begin
				burst_left = $urandom_range(1, 40);
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] phase_ms[7];

		// hold reset, then release it on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset period of 1000 ms. Cover zero speed, phase at zero, exactly half
		// way (full end colour), a quarter, just before wrap, time+offset
		// wrapping past 2^32, the slowest and fastest speeds, equal colours and
		// the coordinate extremes.
		add_directed(mk_pixel(32'd100, 32'd0, 16'h0000, 16'hF800, 16'h07FF, 6'd0, 6'd0));
		add_directed(mk_pixel(32'd0, 32'd0, 16'h0100, 16'h1234, 16'hFFFF, 6'd63, 6'd63));
		add_directed(mk_pixel(32'd500, 32'd0, 16'h0100, 16'h0000, 16'hFFFF, 6'd0, 6'd63));
		add_directed(mk_pixel(32'd250, 32'd0, 16'h0100, 16'hFFFF, 16'h0000, 6'd63, 6'd0));
		add_directed(mk_pixel(32'd999, 32'd0, 16'h0100, 16'h0000, 16'hFFFF, 6'd21, 6'd42));
		add_directed(mk_pixel(32'd499, 32'd0, 16'h0100, 16'hFFFF, 16'h0000, 6'd42, 6'd21));
		add_directed(mk_pixel(32'd501, 32'd0, 16'h0100, 16'h001F, 16'hF800, 6'd1, 6'd2));
		add_directed(mk_pixel(32'hFFFF_FFFF, 32'd1, 16'h0100, 16'hFFFF, 16'h0000, 6'd3, 6'd4));
		add_directed(mk_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0100, 16'h07E0, 16'hF81F,
			6'd5, 6'd6));
		add_directed(mk_pixel(32'd128000, 32'd0, 16'h0001, 16'h0000, 16'hFFFF, 6'd7, 6'd8));
		add_directed(mk_pixel(32'd1, 32'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 6'd9, 6'd10));
		add_directed(mk_pixel(32'd2, 32'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd11, 6'd12));
		add_directed(mk_pixel(32'd3, 32'd4, 16'h8000, 16'hA5A5, 16'h5A5A, 6'd13, 6'd14));
		add_directed(mk_pixel(32'hDEAD_BEEF, 32'h1234_5678, 16'h0180, 16'hA5A5, 16'hA5A5,
			6'd15, 6'd16));
		add_directed(mk_pixel(32'd0, 32'd750, 16'h0100, 16'hFFFF, 16'hFFFF, 6'd17, 6'd18));
		foreach (directed[i]) offer(directed[i]);
		item_valid <= 1'b0;

		// Shortest period: most speeds round the period down to zero
		set_period(16'd1);
		directed.delete();
		add_directed(mk_pixel(32'd7, 32'd0, 16'h0101, 16'h1F00, 16'h00F8, 6'd19, 6'd20));
		add_directed(mk_pixel(32'd7, 32'd9, 16'hFFFF, 16'hFFFF, 16'h0000, 6'd21, 6'd22));
		add_directed(mk_pixel(32'd5, 32'd0, 16'h0100, 16'h0000, 16'hFFFF, 6'd23, 6'd24));
		add_directed(mk_pixel(32'd128, 32'd0, 16'h0001, 16'h0000, 16'hFFFF, 6'd25, 6'd26));
		add_directed(mk_pixel(32'd64, 32'd0, 16'h0001, 16'hFFFF, 16'h0000, 6'd27, 6'd28));
		foreach (directed[i]) offer(directed[i]);
		item_valid <= 1'b0;

		// Longest period: base of 65535 ms at the slowest speed, first at the half-way point
		set_period(16'd65535);
		offer(mk_pixel(32'd8388480, 32'd0, 16'h0001, 16'h0000, 16'hFFFF, 6'd29, 6'd30));
		offer(mk_pixel(32'hFFFF_FFFF, 32'd0, 16'h0001, 16'hFFFF, 16'h0000, 6'd31, 6'd32));
		item_valid <= 1'b0;

		// Random phases, each under its own period; the third one runs back to
		// back against a long receiver hold-off so the input stall shows up.
		phase_ms[0] = 16'd65535;
		phase_ms[1] = 16'd1;
		phase_ms[2] = 16'd1000;
		phase_ms[3] = 16'd256;
		phase_ms[4] = 16'd7;
		phase_ms[5] = 16'($urandom_range(2, 65534));
		phase_ms[6] = 16'($urandom_range(2, 4000));
		for (int ph = 0; ph < 7; ph++) begin
			set_period(phase_ms[ph]);
			if (ph == 2)
				hold_req = 1'b1;
			send_batch(200, ph == 2);
		end

		// let everything come home, then watch a while for stray results
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d pixels over %0d period settings, %0d results compared.",
			sent, settings, chk_checked);
		$display("Long receiver hold-off served: %0d, cycles used: %0d.", hold_taken, cycles);
		if (chk_fails == 0 && chk_outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rtfp_pkg.sv
rtl/core/rtfp_div_cell.sv
rtl/core/rtfp_blend.sv
rtl/core/rgb565_triangle_fade_pixel.sv
tb/rtfp_checker.sv
tb/tb.sv
